// File: hw/rtl/wbr_pkg.sv
// shared types and codes for the windowed block receiver
package wbr_pkg;

   // receive event codes
   localparam logic [2:0] OP_DATA         = 3'd0;
   localparam logic [2:0] OP_OTHER        = 3'd1;
   localparam logic [2:0] OP_ERROR        = 3'd2;
   localparam logic [2:0] OP_TIMEOUT      = 3'd3;
   localparam logic [2:0] OP_SOCKET_ERROR = 3'd4;

   // status codes reported on the result channel
   localparam logic [2:0] STATUS_RECEIVING    = 3'd0;
   localparam logic [2:0] STATUS_DALLYING     = 3'd1;
   localparam logic [2:0] STATUS_FINISHED     = 3'd2;
   localparam logic [2:0] STATUS_GAVE_UP      = 3'd3;
   localparam logic [2:0] STATUS_PEER_ERROR   = 3'd4;
   localparam logic [2:0] STATUS_SOCKET_ERROR = 3'd5;

   // configuration port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // configuration reset values
   localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
   localparam logic [15:0] WINDOW_SIZE_RESET = 16'd1;
   localparam logic [7:0]  MAX_RETRIES_RESET = 8'd5;

   typedef struct packed {
      logic [15:0] blk_size;
      logic [15:0] win_size;
      logic [7:0]  max_retries;
      logic        accept_out_of_order;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] blk_num;
      logic [15:0] data_length;
      logic [15:0] err_code;
   } item_type;

   typedef struct packed {
      logic        send_ack;
      logic [15:0] ack_block;
      logic        append_data;
      logic [2:0]  status;
      logic [15:0] peer_err_code;
      logic [31:0] blocks_received;
   } result_type;

endpackage

// File: hw/rtl/wbr_csr.sv
// configuration registers behind the apb-style port
module wbr_csr
   import wbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
   localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] REG_MAX_RETRIES = 2'd2;
   localparam logic [1:0] REG_OUT_OF_ORDER = 2'd3;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BLOCK_SIZE:   cfg_in.blk_size = pwdata[15:0];
            REG_WINDOW_SIZE:  cfg_in.win_size = pwdata[15:0];
            REG_MAX_RETRIES:  cfg_in.max_retries = pwdata[7:0];
            REG_OUT_OF_ORDER: cfg_in.accept_out_of_order = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blk_size            <= BLOCK_SIZE_RESET;
         cfg_ff.win_size            <= WINDOW_SIZE_RESET;
         cfg_ff.max_retries         <= MAX_RETRIES_RESET;
         cfg_ff.accept_out_of_order <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_BLOCK_SIZE:   prdata = {16'd0, cfg_ff.blk_size};
         REG_WINDOW_SIZE:  prdata = {16'd0, cfg_ff.win_size};
         REG_MAX_RETRIES:  prdata = {24'd0, cfg_ff.max_retries};
         REG_OUT_OF_ORDER: prdata = {31'd0, cfg_ff.accept_out_of_order};
         default:          prdata = '0;
      endcase
   end

endmodule

// File: hw/rtl/wbr_engine.sv
// receiver state and the per-event update logic
module wbr_engine
   import wbr_pkg::*;
#(
   parameter int DALLY_PACKETS = 4
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int DALLY_W = (DALLY_PACKETS > 0) ? $clog2(DALLY_PACKETS + 1) : 1;
   localparam logic [DALLY_W-1:0] DALLY_LIMIT = DALLY_W'(DALLY_PACKETS);

   typedef enum logic [2:0] {
      PH_RECEIVING    = STATUS_RECEIVING,
      PH_DALLYING     = STATUS_DALLYING,
      PH_FINISHED     = STATUS_FINISHED,
      PH_GAVE_UP      = STATUS_GAVE_UP,
      PH_PEER_ERROR   = STATUS_PEER_ERROR,
      PH_SOCKET_ERROR = STATUS_SOCKET_ERROR
   } phase_type;

   phase_type          phase_ff, phase_in, dally_phase;
   logic [31:0]        last_ff, last_in;
   logic [15:0]        since_ff, since_in, since_inc;
   logic [8:0]         tmo_ff, tmo_in, tmo_inc;
   logic [DALLY_W-1:0] dally_ff, dally_in, dally_inc;
   logic [31:0]        accepted_ff, accepted_in;
   logic [15:0]        held_ff, held_in;
   logic [15:0]        win;
   logic [15:0]        fwd;
   logic               is_final;
   logic               ack;
   logic               append;

   // helpers shared by the event cases
   always_comb begin
      win         = (cfg.win_size == 16'd0) ? 16'd1 : cfg.win_size;
      fwd         = item.blk_num - last_ff[15:0];
      since_inc   = since_ff + 16'd1;
      tmo_inc     = tmo_ff + 9'd1;
      dally_inc   = dally_ff + DALLY_W'(1);
      is_final    = item.data_length < cfg.blk_size;
      dally_phase = (DALLY_PACKETS == 0) ? PH_FINISHED : PH_DALLYING;
   end

   // next state for one receive event
   always_comb begin
      phase_in    = phase_ff;
      last_in     = last_ff;
      since_in    = since_ff;
      tmo_in      = tmo_ff;
      dally_in    = dally_ff;
      accepted_in = accepted_ff;
      held_in     = held_ff;
      ack         = 1'b0;
      append      = 1'b0;
      case (phase_ff)
         PH_RECEIVING: begin
            case (item.op)
               OP_SOCKET_ERROR: phase_in = PH_SOCKET_ERROR;
               OP_TIMEOUT: begin
                  tmo_in = tmo_inc;
                  if (tmo_inc > {1'b0, cfg.max_retries}) begin
                     phase_in = PH_GAVE_UP;
                  end else begin
                     ack = 1'b1;
                  end
               end
               OP_ERROR: begin
                  held_in  = item.err_code;
                  phase_in = PH_PEER_ERROR;
               end
               OP_DATA: begin
                  tmo_in = '0;
                  ack    = 1'b1;
                  if (fwd == 16'd1) begin
                     // next block in order
                     append      = 1'b1;
                     last_in     = last_ff + {16'd0, fwd};
                     accepted_in = accepted_ff + 32'd1;
                     since_in    = since_inc;
                     if (is_final) begin
                        dally_in = '0;
                        phase_in = dally_phase;
                     end else if (since_inc >= win) begin
                        since_in = '0;
                     end else begin
                        ack = 1'b0;
                     end
                  end else if (fwd != 16'd0 && fwd <= win) begin
                     // gap inside the window
                     if (cfg.accept_out_of_order) begin
                        append      = 1'b1;
                        last_in     = last_ff + {16'd0, fwd};
                        accepted_in = accepted_ff + 32'd1;
                        if (is_final) begin
                           dally_in = '0;
                           phase_in = dally_phase;
                        end
                     end else begin
                        since_in = '0;
                     end
                  end else begin
                     // duplicate or unplaced block, re-ack
                     since_in = '0;
                  end
               end
               default: ;
            endcase
         end
         PH_DALLYING: begin
            if (item.op == OP_TIMEOUT || item.op == OP_SOCKET_ERROR) begin
               phase_in = PH_FINISHED;
            end else begin
               ack      = (item.op == OP_DATA);
               dally_in = dally_inc;
               if (dally_inc >= DALLY_LIMIT) begin
                  phase_in = PH_FINISHED;
               end
            end
         end
         default: ;
      endcase
   end

   // result of the current transaction
   always_comb begin
      result.send_ack        = ack;
      result.ack_block       = last_in[15:0];
      result.append_data     = append;
      result.status          = phase_in;
      result.peer_err_code   = held_in;
      result.blocks_received = accepted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_RECEIVING;
         last_ff     <= '0;
         since_ff    <= '0;
         tmo_ff      <= '0;
         dally_ff    <= '0;
         accepted_ff <= '0;
         held_ff     <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         last_ff     <= last_in;
         since_ff    <= since_in;
         tmo_ff      <= tmo_in;
         dally_ff    <= dally_in;
         accepted_ff <= accepted_in;
         held_ff     <= held_in;
      end
   end

   // appended data always bumps the accepted count by one
   assert property (@(posedge clock) disable iff (reset)
      fire && append |-> accepted_in == accepted_ff + 32'd1)
      else $error("append without count increment");

   // an ended phase never changes again
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FINISHED || phase_ff == PH_GAVE_UP ||
       phase_ff == PH_PEER_ERROR || phase_ff == PH_SOCKET_ERROR) |=> $stable(phase_ff))
      else $error("ended phase changed");

   // ended phases neither ack nor append
   assert property (@(posedge clock) disable iff (reset)
      fire && (phase_ff == PH_FINISHED || phase_ff == PH_GAVE_UP ||
               phase_ff == PH_PEER_ERROR || phase_ff == PH_SOCKET_ERROR)
      |-> !ack && !append)
      else $error("activity after end of transfer");

endmodule

// File: hw/rtl/windowed_block_receiver.sv
// top level: input register, receiver engine, result register, csr port
// result path: req_ into the input register, engine, result register onto rsp_
// throughput: one receive event per cycle while rsp_ is not stalled
// stall on rsp_ holds the result register; the input register still takes one more
// reset (synchronous): pipeline empty, state cleared, config back to defaults
module windowed_block_receiver
   import wbr_pkg::*;
#(
   parameter int DALLY_PACKETS = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_op,
   input  logic [15:0]           req_blk_num,
   input  logic [15:0]           req_data_length,
   input  logic [15:0]           req_err_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_send_ack,
   output logic [15:0]           rsp_ack_block,
   output logic                  rsp_append_data,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_peer_err_code,
   output logic [31:0]           rsp_blocks_received,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type step_result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_load;
   logic       advance;

   wbr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   wbr_engine #(
      .DALLY_PACKETS (DALLY_PACKETS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   // pipeline flow control
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.op          <= req_op;
         item_ff.blk_num     <= req_blk_num;
         item_ff.data_length <= req_data_length;
         item_ff.err_code    <= req_err_code;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_send_ack        = out_ff.send_ack;
   assign rsp_ack_block       = out_ff.ack_block;
   assign rsp_append_data     = out_ff.append_data;
   assign rsp_status          = out_ff.status;
   assign rsp_peer_err_code   = out_ff.peer_err_code;
   assign rsp_blocks_received = out_ff.blocks_received;

endmodule

// File: test/windowed_block_receiver_tb.sv
// testbench for the windowed block receiver: random and directed receive events, scoreboard
module windowed_block_receiver_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wbr_pkg::*;

   localparam int DALLY_LIMIT = 4;
   localparam int CYCLE_LIMIT = 500000;

   // register byte addresses
   localparam logic [CSR_ADDR_W-1:0] REG_BLOCK_SIZE   = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_SIZE  = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_RETRIES  = 4'h8;
   localparam logic [CSR_ADDR_W-1:0] REG_OUT_OF_ORDER = 4'hC;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic     req_valid = 1'b0;
   logic     req_stall;
   item_type current_event = '0;
   item_type next_event;

   // response channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_send_ack;
   logic [15:0] rsp_ack_block;
   logic        rsp_append_data;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_peer_err_code;
   logic [31:0] rsp_blocks_received;

   // csr port
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register copy and receiver state as predicted
   cfg_type shadow_cfg = '{blk_size: BLOCK_SIZE_RESET, win_size: WINDOW_SIZE_RESET,
                           max_retries: MAX_RETRIES_RESET, accept_out_of_order: 1'b0};
   logic [31:0] last_block = '0;
   logic [15:0] since_ack = '0;
   logic [8:0]  timeout_run = '0;
   logic [2:0]  rx_phase = STATUS_RECEIVING;
   logic [3:0]  dally_events = '0;
   logic [31:0] accepted_blocks = '0;
   logic [15:0] held_code = '0;

   // stimulus side view: where the transfer stands while it is still receiving
   logic [15:0] gen_last = '0;
   int          gen_timeouts = 0;

   item_type   pending_events[$];
   result_type expected_replies[$];
   result_type wanted_reply;

   int send_gap = 0;
   bit send_burst = 1'b0;
   int recv_hold = 0;
   int recv_draw;
   bit recv_burst = 1'b0;

   int mismatch_count = 0;
   int events_sent = 0;
   int replies_checked = 0;
   int ack_count = 0;
   int append_count = 0;
   int settings_used = 0;
   int cycle_count = 0;
   logic [2:0] last_status = STATUS_RECEIVING;

   windowed_block_receiver #(
      .DALLY_PACKETS(DALLY_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(current_event.op),
      .req_blk_num(current_event.blk_num),
      .req_data_length(current_event.data_length),
      .req_err_code(current_event.err_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_send_ack(rsp_send_ack),
      .rsp_ack_block(rsp_ack_block),
      .rsp_append_data(rsp_append_data),
      .rsp_status(rsp_status),
      .rsp_peer_err_code(rsp_peer_err_code),
      .rsp_blocks_received(rsp_blocks_received),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      $display("%0t reply %0d: %s got %0h expected %0h", $realtime, replies_checked, what,
               got, want);
   endtask

   // lingering phase after the final block
   function automatic void start_dally();
      dally_events = '0;
      rx_phase = (DALLY_LIMIT == 0) ? STATUS_FINISHED : STATUS_DALLYING;
   endfunction

   // receiver state update for one receive event, returns the reply it produces
   function automatic result_type advance_receiver(input item_type ev);
      result_type  r;
      logic        ack;
      logic        append;
      logic [15:0] win;
      logic [15:0] fwd;
      ack = 1'b0;
      append = 1'b0;
      win = (shadow_cfg.win_size == 16'd0) ? 16'd1 : shadow_cfg.win_size;
      fwd = ev.blk_num - last_block[15:0];
      case (rx_phase)
         STATUS_RECEIVING: begin
            if (ev.op == OP_SOCKET_ERROR) begin
               rx_phase = STATUS_SOCKET_ERROR;
            end else if (ev.op == OP_TIMEOUT) begin
               timeout_run = timeout_run + 9'd1;
               if (timeout_run > {1'b0, shadow_cfg.max_retries}) rx_phase = STATUS_GAVE_UP;
               else ack = 1'b1;
            end else if (ev.op == OP_ERROR) begin
               held_code = ev.err_code;
               rx_phase = STATUS_PEER_ERROR;
            end else if (ev.op == OP_DATA) begin
               timeout_run = '0;
               if (fwd == 16'd1) begin
                  // next block in order
                  append = 1'b1;
                  last_block = last_block + 32'd1;
                  accepted_blocks = accepted_blocks + 32'd1;
                  since_ack = since_ack + 16'd1;
                  if (ev.data_length < shadow_cfg.blk_size) begin
                     ack = 1'b1;
                     start_dally();
                  end else if (since_ack >= win) begin
                     ack = 1'b1;
                     since_ack = '0;
                  end
               end else if (fwd != 16'd0 && fwd <= win) begin
                  // gap inside the window: re-ack, or jump ahead with the quirk
                  ack = 1'b1;
                  if (shadow_cfg.accept_out_of_order) begin
                     append = 1'b1;
                     last_block = last_block + {16'd0, fwd};
                     accepted_blocks = accepted_blocks + 32'd1;
                     if (ev.data_length < shadow_cfg.blk_size) start_dally();
                  end else begin
                     since_ack = '0;
                  end
               end else begin
                  // duplicate or unplaced block
                  ack = 1'b1;
                  since_ack = '0;
               end
            end
         end
         STATUS_DALLYING: begin
            if (ev.op == OP_TIMEOUT || ev.op == OP_SOCKET_ERROR) begin
               rx_phase = STATUS_FINISHED;
            end else begin
               if (ev.op == OP_DATA) ack = 1'b1;
               dally_events = dally_events + 4'd1;
               if (dally_events >= DALLY_LIMIT) rx_phase = STATUS_FINISHED;
            end
         end
         default: ;
      endcase
      r.send_ack = ack;
      r.ack_block = last_block[15:0];
      r.append_data = append;
      r.status = rx_phase;
      r.peer_err_code = held_code;
      r.blocks_received = accepted_blocks;
      return r;
   endfunction

   // queue one event; accepted data stays full length unless it may end the transfer
   task automatic queue_event(input item_type ev, input bit may_end);
      logic [15:0] win;
      logic [15:0] fwd;
      win = (shadow_cfg.win_size == 16'd0) ? 16'd1 : shadow_cfg.win_size;
      if (ev.op == OP_DATA) begin
         fwd = ev.blk_num - gen_last;
         if (fwd == 16'd1 || (shadow_cfg.accept_out_of_order && fwd != 16'd0 && fwd <= win))
         begin
            if (!may_end && ev.data_length < shadow_cfg.blk_size)
               ev.data_length = 16'($urandom_range(shadow_cfg.blk_size, 16'hFFFF));
            gen_last = ev.blk_num;
         end
         gen_timeouts = 0;
      end else if (ev.op == OP_TIMEOUT) begin
         gen_timeouts++;
      end
      pending_events.insert(pending_events.size(), ev);
   endtask

   task automatic queue_fields(input logic [2:0] op, input logic [15:0] blk_num,
                               input logic [15:0] data_length, input logic [15:0] err_code);
      item_type ev;
      ev.op = op;
      ev.blk_num = blk_num;
      ev.data_length = data_length;
      ev.err_code = err_code;
      queue_event(ev, 1'b0);
   endtask

   // random event that keeps the transfer alive
   task automatic queue_random_event();
      item_type    ev;
      int          pick;
      logic [15:0] win;
      win = (shadow_cfg.win_size == 16'd0) ? 16'd1 : shadow_cfg.win_size;
      ev.op = OP_DATA;
      ev.blk_num = 16'($urandom);
      ev.data_length = 16'($urandom);
      ev.err_code = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) ev.blk_num = gen_last + 16'd1;
      else if (pick < 65) ev.blk_num = gen_last - 16'($urandom_range(0, int'(win) + 2));
      else if (pick < 75) ev.blk_num = gen_last + 16'($urandom_range(2, int'(win) + 1));
      else if (pick < 80) ;
      else if (pick < 90) ev.op = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : OP_OTHER;
      else ev.op = (gen_timeouts < shadow_cfg.max_retries) ? OP_TIMEOUT : OP_OTHER;
      queue_event(ev, 1'b0);
   endtask

   // close the transfer one of four ways, then keep poking the ended receiver
   task automatic queue_ending();
      item_type    ev;
      int          pick;
      logic [15:0] win;
      win = (shadow_cfg.win_size == 16'd0) ? 16'd1 : shadow_cfg.win_size;
      ev.blk_num = 16'($urandom);
      ev.data_length = 16'($urandom);
      ev.err_code = 16'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            // short final block, in order or a jump with the quirk, then dally
            ev.op = OP_DATA;
            if (shadow_cfg.accept_out_of_order && win >= 16'd2 && $urandom_range(0, 1))
               ev.blk_num = gen_last + 16'($urandom_range(2, win));
            else
               ev.blk_num = gen_last + 16'd1;
            ev.data_length = 16'($urandom_range(0, shadow_cfg.blk_size - 16'd1));
            queue_event(ev, 1'b1);
            repeat (6) begin
               pick = $urandom_range(0, 99);
               ev.blk_num = 16'($urandom);
               ev.data_length = 16'($urandom);
               ev.err_code = 16'($urandom);
               if (pick < 50) ev.op = OP_DATA;
               else if (pick < 70) ev.op = OP_OTHER;
               else if (pick < 80) ev.op = OP_ERROR;
               else if (pick < 88) ev.op = 3'($urandom_range(5, 7));
               else if (pick < 94) ev.op = OP_TIMEOUT;
               else ev.op = OP_SOCKET_ERROR;
               queue_event(ev, 1'b1);
            end
         end
         1: begin
            // duplicate clears the count, then timeouts until giving up
            queue_fields(OP_DATA, gen_last, 16'($urandom), 16'($urandom));
            repeat (int'(shadow_cfg.max_retries) + 1)
               queue_fields(OP_TIMEOUT, 16'($urandom), 16'($urandom), 16'($urandom));
         end
         2: begin
            ev.op = OP_ERROR;
            queue_event(ev, 1'b1);
         end
         default: begin
            ev.op = OP_SOCKET_ERROR;
            queue_event(ev, 1'b1);
         end
      endcase
      repeat (20) begin
         ev.op = 3'($urandom_range(0, 7));
         ev.blk_num = 16'($urandom);
         ev.data_length = 16'($urandom);
         ev.err_code = 16'($urandom);
         queue_event(ev, 1'b1);
      end
   endtask

   // one apb transfer: setup, then access until ready
   task automatic csr_cycle(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value,
                                 input logic [31:0] mask);
      logic [31:0] readback;
      csr_cycle(1'b1, addr, value, readback);
      csr_cycle(1'b0, addr, 32'd0, readback);
      if ((readback & mask) !== (value & mask))
         note_mismatch("register readback", readback & mask, value & mask);
   endtask

   task automatic set_registers(input logic [15:0] blk_size, input logic [15:0] win_size,
                                input logic [7:0] max_retries, input logic out_of_order);
      write_register(REG_BLOCK_SIZE, {16'd0, blk_size}, 32'h0000FFFF);
      write_register(REG_WINDOW_SIZE, {16'd0, win_size}, 32'h0000FFFF);
      write_register(REG_MAX_RETRIES, {24'd0, max_retries}, 32'h000000FF);
      write_register(REG_OUT_OF_ORDER, {31'd0, out_of_order}, 32'h00000001);
      shadow_cfg.blk_size = blk_size;
      shadow_cfg.win_size = win_size;
      shadow_cfg.max_retries = max_retries;
      shadow_cfg.accept_out_of_order = out_of_order;
      settings_used++;
   endtask

   // sender holds off until every queued transaction has its reply
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_valid || expected_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.insert(expected_replies.size(), advance_receiver(current_event));
            events_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_events.size() != 0) begin
               next_event = pending_events.pop_front();
               current_event <= next_event;
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_burst <= !send_burst;
               send_gap <= send_burst ? 0 : $urandom_range(0, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and scoreboard
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_hold <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         replies_checked++;
         if (rsp_send_ack) ack_count++;
         if (rsp_append_data) append_count++;
         last_status = rsp_status;
         if (expected_replies.size() == 0) begin
            note_mismatch("reply with nothing expected", 32'(rsp_ack_block), 32'd0);
         end else begin
            wanted_reply = expected_replies.pop_front();
            if (rsp_send_ack !== wanted_reply.send_ack)
               note_mismatch("send_ack", 32'(rsp_send_ack), 32'(wanted_reply.send_ack));
            if (rsp_ack_block !== wanted_reply.ack_block)
               note_mismatch("ack_block", 32'(rsp_ack_block), 32'(wanted_reply.ack_block));
            if (rsp_append_data !== wanted_reply.append_data)
               note_mismatch("append_data", 32'(rsp_append_data),
                             32'(wanted_reply.append_data));
            if (rsp_status !== wanted_reply.status)
               note_mismatch("status", 32'(rsp_status), 32'(wanted_reply.status));
            if (rsp_peer_err_code !== wanted_reply.peer_err_code)
               note_mismatch("peer error code", 32'(rsp_peer_err_code),
                             32'(wanted_reply.peer_err_code));
            if (rsp_blocks_received !== wanted_reply.blocks_received)
               note_mismatch("blocks_received", rsp_blocks_received,
                             wanted_reply.blocks_received);
         end
         if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
         recv_draw = recv_burst ? 0 : $urandom_range(0, 15);
         rsp_stall <= (recv_draw != 0);
         recv_hold <= recv_draw;
      end else if (recv_hold != 0) begin
         rsp_stall <= (recv_hold > 1);
         recv_hold <= recv_hold - 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies still expected", cycle_count,
                  expected_replies.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: in order, duplicates, gaps, ignored packets, timeouts
      queue_fields(OP_DATA, 16'd1, 16'd512, 16'd0);
      queue_fields(OP_DATA, 16'd2, 16'hFFFF, 16'h0000);
      queue_fields(OP_DATA, 16'd2, 16'd0, 16'd0);
      queue_fields(OP_DATA, 16'd0, 16'd0, 16'd0);
      queue_fields(OP_DATA, 16'd5, 16'd100, 16'd0);
      queue_fields(OP_DATA, 16'hFFFF, 16'd0, 16'd0);
      queue_fields(OP_OTHER, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_fields(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_fields(3'd6, 16'h0000, 16'h0000, 16'h0000);
      queue_fields(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (5) queue_fields(OP_TIMEOUT, 16'd0, 16'd0, 16'd0);
      queue_fields(OP_DATA, 16'd3, 16'd512, 16'd0);
      queue_fields(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_fields(OP_DATA, 16'd4, 16'hFFFF, 16'hFFFF);
      repeat (150) queue_random_event();
      wait_idle();

      // smallest blocks, widest window, no retries, quirk on: every nonzero offset is forward
      set_registers(16'd8, 16'hFFFF, 8'd0, 1'b1);
      queue_fields(OP_DATA, gen_last + 16'hFFFF, 16'd8, 16'hFFFF);
      queue_fields(OP_DATA, gen_last + 16'd1, 16'd8, 16'd0);
      queue_fields(OP_DATA, gen_last - 16'd100, 16'd0, 16'd0);
      repeat (200) queue_random_event();
      wait_idle();

      // largest blocks, single window, most retries
      set_registers(16'd65464, 16'd1, 8'd255, 1'b0);
      repeat (200) queue_random_event();
      wait_idle();

      // zero window behaves as a window of one
      set_registers(16'($urandom_range(8, 4096)), 16'd0, 8'($urandom_range(0, 10)), 1'b0);
      repeat (150) queue_random_event();

      for (int p = 0; p < 4; p++) begin
         logic [15:0] bs;
         logic [15:0] win;
         logic [7:0]  retries;
         wait_idle();
         case ($urandom_range(0, 3))
            0: bs = 16'd8;
            1: bs = 16'd65464;
            2: bs = 16'($urandom_range(8, 2048));
            default: bs = 16'($urandom_range(8, 65464));
         endcase
         case ($urandom_range(0, 3))
            0: win = 16'd1;
            1: win = 16'hFFFF;
            2: win = 16'($urandom_range(1, 8));
            default: win = 16'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 2))
            0: retries = 8'd0;
            1: retries = 8'd255;
            default: retries = 8'($urandom_range(0, 8));
         endcase
         set_registers(bs, win, retries, 1'($urandom_range(0, 1)));
         repeat (175) queue_random_event();
      end
      wait_idle();

      queue_ending();
      wait_idle();
      repeat (8) @(posedge clock);

      $display("checked %0d replies for %0d receive events under %0d register settings",
               replies_checked, events_sent, settings_used + 1);
      $display("acks %0d, appended blocks %0d, transfer ended with status %0d",
               ack_count, append_count, last_status);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
